// ----- hw/rtl/tvdg_pkg.sv -----
// Shared types and constants of the threshold vote decision gate.
package tvdg_pkg;

    // Decision limits and fixed field widths.
    localparam int MAX_REGIMES = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int NET_W       = 8;
    localparam int SIDE_W      = 2;
    localparam int WIDTH_W     = 31;
    localparam int CENTER_W    = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Reset value of both threshold widths: the 2 bps floor in Q7.24.
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 31'd3355;

    // Encodings of the reported side.
    localparam logic signed [SIDE_W-1:0] SIDE_FLAT  = 2'sb00;
    localparam logic signed [SIDE_W-1:0] SIDE_LONG  = 2'sb01;
    localparam logic signed [SIDE_W-1:0] SIDE_SHORT = 2'sb11;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH_LONG   = 3'd0,
        REG_WIDTH_SHORT  = 3'd1,
        REG_CENTER_LONG  = 3'd2,
        REG_CENTER_SHORT = 3'd3,
        REG_REVERSE_SIDE = 3'd4
    } t_cfg_reg;

    // Source of the representative voter.
    typedef enum logic [1:0] {
        PICK_NONE,
        PICK_LONG,
        PICK_SHORT
    } t_pick;

    // Configuration register file contents.
    typedef struct packed {
        logic [WIDTH_W-1:0]         width_long;
        logic [WIDTH_W-1:0]         width_short;
        logic signed [CENTER_W-1:0] center_long;
        logic signed [CENTER_W-1:0] center_short;
        logic                       reverse_side;
    } t_cfg;

    // Classified item flags between the classifier and the accumulator.
    typedef struct packed {
        logic vld;
        logic last;
        logic is_short;
        logic vote;
    } t_vote_ctl;

    // Closed decision snapshot between the accumulator and the result stage.
    typedef struct packed {
        logic               vld;
        logic [CNT_W-1:0]   long_cnt;
        logic [CNT_W-1:0]   short_cnt;
        logic               long_found;
        logic               short_found;
        logic [IDX_W-1:0]   long_idx;
        logic [IDX_W-1:0]   short_idx;
    } t_snap_ctl;

endpackage

// ----- hw/rtl/tvdg_in_if.sv -----
// Input channel carrying one regime prediction per transaction.
interface tvdg_in_if #(
    parameter int PRED_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         leg;
    logic signed [PRED_WIDTH-1:0] prediction;
    logic                         pred_invalid;
    logic                         last_regime;

    modport source (
        output valid, leg, prediction, pred_invalid, last_regime,
        input  ready
    );
    modport sink (
        input  valid, leg, prediction, pred_invalid, last_regime,
        output ready
    );
endinterface

// ----- hw/rtl/tvdg_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface tvdg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tvdg_pkg::CFG_IDX_W-1:0]   index;
    logic [tvdg_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- hw/rtl/tvdg_out_if.sv -----
// Output channel carrying one decision result per transaction.
interface tvdg_out_if #(
    parameter int PRED_WIDTH = 32
);
    logic                                   valid;
    logic                                   ready;
    logic [tvdg_pkg::CNT_W-1:0]             long_votes;
    logic [tvdg_pkg::CNT_W-1:0]             short_votes;
    logic [tvdg_pkg::CNT_W-1:0]             total_votes;
    logic signed [tvdg_pkg::NET_W-1:0]      net_votes;
    logic signed [tvdg_pkg::SIDE_W-1:0]     side;
    logic                                   fired;
    logic                                   has_winner;
    logic [tvdg_pkg::IDX_W-1:0]             winner_index;
    logic signed [PRED_WIDTH-1:0]           winner_prediction;
    logic [tvdg_pkg::WIDTH_W-1:0]           winner_width;
    logic signed [tvdg_pkg::CENTER_W-1:0]   winner_center;

    modport source (
        output valid, long_votes, short_votes, total_votes, net_votes, side, fired,
               has_winner, winner_index, winner_prediction, winner_width, winner_center,
        input  ready
    );
    modport sink (
        input  valid, long_votes, short_votes, total_votes, net_votes, side, fired,
               has_winner, winner_index, winner_prediction, winner_width, winner_center,
        output ready
    );
endinterface

// ----- hw/rtl/tvdg_classify.sv -----
// Input register and threshold classification of each prediction.
module tvdg_classify #(
    parameter int PRED_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tvdg_in_if.sink                      i_in,
    input  tvdg_pkg::t_cfg               i_cfg,
    input  logic                         i_rdy,
    output tvdg_pkg::t_vote_ctl          o_ctl,
    output logic signed [PRED_WIDTH-1:0] o_pred,
    output logic [PRED_WIDTH-1:0]        o_abs
);
    // Compare width holds a center plus a width and any prediction.
    localparam int CMP_W = (PRED_WIDTH > 33) ? PRED_WIDTH : 33;

    logic                         r_a_vld;
    logic                         r_a_leg;
    logic signed [PRED_WIDTH-1:0] r_a_pred;
    logic                         r_a_invalid;
    logic                         r_a_last;

    tvdg_pkg::t_vote_ctl          r_b_ctl;
    tvdg_pkg::t_vote_ctl          n_b_ctl;
    logic signed [PRED_WIDTH-1:0] r_b_pred;
    logic [PRED_WIDTH-1:0]        r_b_abs;
    logic [PRED_WIDTH-1:0]        n_b_abs;

    logic                         w_b_free;
    logic                         w_a_free;
    logic signed [CMP_W-1:0]      w_pred_ext;
    logic signed [CMP_W-1:0]      w_long_lim;
    logic signed [CMP_W-1:0]      w_short_lim;
    logic                         w_above;
    logic                         w_below;

    // Stage B frees when empty or when the accumulator takes its item.
    assign w_b_free   = !r_b_ctl.vld || i_rdy;
    assign w_a_free   = !r_a_vld || w_b_free;
    assign i_in.ready = w_a_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_a_free) begin
            r_a_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_free && i_in.valid) begin
            r_a_leg     <= i_in.leg;
            r_a_pred    <= i_in.prediction;
            r_a_invalid <= i_in.pred_invalid;
            r_a_last    <= i_in.last_regime;
        end
    end

    // Exact threshold edges and strict comparisons.
    always_comb begin
        w_pred_ext  = CMP_W'(r_a_pred);
        w_long_lim  = CMP_W'(i_cfg.center_long) + $signed(CMP_W'(i_cfg.width_long));
        w_short_lim = CMP_W'(i_cfg.center_short) - $signed(CMP_W'(i_cfg.width_short));
        w_above     = w_pred_ext > w_long_lim;
        w_below     = w_pred_ext < w_short_lim;

        n_b_ctl.vld      = r_a_vld;
        n_b_ctl.last     = r_a_last;
        n_b_ctl.is_short = r_a_leg;
        n_b_ctl.vote     = !r_a_invalid && (r_a_leg ? w_below : w_above);

        // Magnitude; the most negative value maps to 2^(PRED_WIDTH-1).
        n_b_abs = r_a_pred[PRED_WIDTH-1] ? PRED_WIDTH'(-r_a_pred) : PRED_WIDTH'(r_a_pred);
    end

    // Classified item register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (w_b_free) begin
            r_b_ctl <= n_b_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_free && r_a_vld) begin
            r_b_pred <= r_a_pred;
            r_b_abs  <= n_b_abs;
        end
    end

    assign o_ctl  = r_b_ctl;
    assign o_pred = r_b_pred;
    assign o_abs  = r_b_abs;

endmodule

// ----- hw/rtl/tvdg_accum.sv -----
// Per-leg vote counters and best-voter tracking over one decision.
module tvdg_accum #(
    parameter int PRED_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tvdg_pkg::t_vote_ctl          i_ctl,
    input  logic signed [PRED_WIDTH-1:0] i_pred,
    input  logic [PRED_WIDTH-1:0]        i_abs,
    output logic                         o_rdy,
    input  logic                         i_rdy,
    output tvdg_pkg::t_snap_ctl          o_snap,
    output logic [PRED_WIDTH-1:0]        o_long_abs,
    output logic signed [PRED_WIDTH-1:0] o_long_pred,
    output logic [PRED_WIDTH-1:0]        o_short_abs,
    output logic signed [PRED_WIDTH-1:0] o_short_pred
);
    localparam int CNT_W = tvdg_pkg::CNT_W;
    localparam int IDX_W = tvdg_pkg::IDX_W;

    // Decision state.
    logic [CNT_W-1:0]             r_item_cnt, n_item_cnt;
    logic [CNT_W-1:0]             r_long_cnt, n_long_cnt;
    logic [CNT_W-1:0]             r_short_cnt, n_short_cnt;
    logic                         r_long_found, n_long_found;
    logic                         r_short_found, n_short_found;
    logic [PRED_WIDTH-1:0]        r_long_abs, n_long_abs;
    logic [PRED_WIDTH-1:0]        r_short_abs, n_short_abs;
    logic [IDX_W-1:0]             r_long_idx, n_long_idx;
    logic [IDX_W-1:0]             r_short_idx, n_short_idx;
    logic signed [PRED_WIDTH-1:0] r_long_pred, n_long_pred;
    logic signed [PRED_WIDTH-1:0] r_short_pred, n_short_pred;

    // Snapshot of a closed decision.
    tvdg_pkg::t_snap_ctl          r_snap, n_snap;
    logic [PRED_WIDTH-1:0]        r_s_long_abs, r_s_short_abs;
    logic signed [PRED_WIDTH-1:0] r_s_long_pred, r_s_short_pred;

    logic                         w_snap_free;
    logic                         w_consume;
    logic                         w_counted;
    logic [IDX_W-1:0]             w_idx;
    logic                         w_long_vote;
    logic                         w_short_vote;
    logic                         w_long_upd;
    logic                         w_short_upd;

    // A last item waits until the snapshot register is free.
    assign w_snap_free = !r_snap.vld || i_rdy;
    assign o_rdy       = !i_ctl.last || w_snap_free;
    assign w_consume   = i_ctl.vld && o_rdy;

    // Next decision state with the incoming item folded in.
    always_comb begin
        w_counted    = r_item_cnt < CNT_W'(tvdg_pkg::MAX_REGIMES);
        w_idx        = r_item_cnt[IDX_W-1:0];
        w_long_vote  = w_counted && i_ctl.vote && !i_ctl.is_short;
        w_short_vote = w_counted && i_ctl.vote && i_ctl.is_short;

        n_item_cnt  = r_item_cnt + CNT_W'(w_counted);
        n_long_cnt  = r_long_cnt + CNT_W'(w_long_vote);
        n_short_cnt = r_short_cnt + CNT_W'(w_short_vote);

        // Strictly larger magnitude replaces, so the earlier voter keeps ties.
        w_long_upd  = w_long_vote && (!r_long_found || i_abs > r_long_abs);
        w_short_upd = w_short_vote && (!r_short_found || i_abs > r_short_abs);

        n_long_found  = r_long_found || w_long_vote;
        n_short_found = r_short_found || w_short_vote;
        n_long_abs    = w_long_upd ? i_abs : r_long_abs;
        n_long_idx    = w_long_upd ? w_idx : r_long_idx;
        n_long_pred   = w_long_upd ? i_pred : r_long_pred;
        n_short_abs   = w_short_upd ? i_abs : r_short_abs;
        n_short_idx   = w_short_upd ? w_idx : r_short_idx;
        n_short_pred  = w_short_upd ? i_pred : r_short_pred;

        n_snap.vld         = w_consume && i_ctl.last;
        n_snap.long_cnt    = n_long_cnt;
        n_snap.short_cnt   = n_short_cnt;
        n_snap.long_found  = n_long_found;
        n_snap.short_found = n_short_found;
        n_snap.long_idx    = n_long_idx;
        n_snap.short_idx   = n_short_idx;
    end

    // Counters and found flags; a last item clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_cnt    <= '0;
            r_long_cnt    <= '0;
            r_short_cnt   <= '0;
            r_long_found  <= 1'b0;
            r_short_found <= 1'b0;
        end else if (w_consume) begin
            if (i_ctl.last) begin
                r_item_cnt    <= '0;
                r_long_cnt    <= '0;
                r_short_cnt   <= '0;
                r_long_found  <= 1'b0;
                r_short_found <= 1'b0;
            end else begin
                r_item_cnt    <= n_item_cnt;
                r_long_cnt    <= n_long_cnt;
                r_short_cnt   <= n_short_cnt;
                r_long_found  <= n_long_found;
                r_short_found <= n_short_found;
            end
        end
    end

    // Best-voter payload; only read while the matching found flag is set.
    always_ff @(posedge i_clk) begin
        if (w_consume) begin
            r_long_abs   <= n_long_abs;
            r_long_idx   <= n_long_idx;
            r_long_pred  <= n_long_pred;
            r_short_abs  <= n_short_abs;
            r_short_idx  <= n_short_idx;
            r_short_pred <= n_short_pred;
        end
    end

    // Snapshot register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap <= '0;
        end else if (w_snap_free) begin
            r_snap <= n_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_snap_free && n_snap.vld) begin
            r_s_long_abs   <= n_long_abs;
            r_s_long_pred  <= n_long_pred;
            r_s_short_abs  <= n_short_abs;
            r_s_short_pred <= n_short_pred;
        end
    end

    assign o_snap       = r_snap;
    assign o_long_abs   = r_s_long_abs;
    assign o_long_pred  = r_s_long_pred;
    assign o_short_abs  = r_s_short_abs;
    assign o_short_pred = r_s_short_pred;

endmodule

// ----- hw/rtl/tvdg_result.sv -----
// Side, net count and representative voter selection into the output register.
module tvdg_result #(
    parameter int PRED_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tvdg_pkg::t_cfg               i_cfg,
    input  tvdg_pkg::t_snap_ctl          i_snap,
    input  logic [PRED_WIDTH-1:0]        i_long_abs,
    input  logic signed [PRED_WIDTH-1:0] i_long_pred,
    input  logic [PRED_WIDTH-1:0]        i_short_abs,
    input  logic signed [PRED_WIDTH-1:0] i_short_pred,
    output logic                         o_rdy,
    tvdg_out_if.source                   o_out
);
    localparam int CNT_W    = tvdg_pkg::CNT_W;
    localparam int NET_W    = tvdg_pkg::NET_W;
    localparam int SIDE_W   = tvdg_pkg::SIDE_W;
    localparam int IDX_W    = tvdg_pkg::IDX_W;
    localparam int WIDTH_W  = tvdg_pkg::WIDTH_W;
    localparam int CENTER_W = tvdg_pkg::CENTER_W;

    logic                                r_vld;
    logic [CNT_W-1:0]                    r_long_votes, r_short_votes, r_total_votes;
    logic signed [NET_W-1:0]             r_net_votes, n_net_votes;
    logic signed [SIDE_W-1:0]            r_side, n_side;
    logic                                r_fired, r_has_winner;
    logic [IDX_W-1:0]                    r_win_idx, n_win_idx;
    logic signed [PRED_WIDTH-1:0]        r_win_pred, n_win_pred;
    logic [WIDTH_W-1:0]                  r_win_width, n_win_width;
    logic signed [CENTER_W-1:0]          r_win_center, n_win_center;
    tvdg_pkg::t_pick                     w_pick;
    logic                                w_load;

    assign o_rdy  = !r_vld || o_out.ready;
    assign w_load = o_rdy && i_snap.vld;

    // Net count, side and the leg of the representative voter.
    always_comb begin
        n_net_votes = $signed(NET_W'(i_snap.long_cnt)) - $signed(NET_W'(i_snap.short_cnt));

        if (n_net_votes > 0) begin
            n_side = i_cfg.reverse_side ? tvdg_pkg::SIDE_SHORT : tvdg_pkg::SIDE_LONG;
            w_pick = i_snap.long_found ? tvdg_pkg::PICK_LONG : tvdg_pkg::PICK_NONE;
        end else if (n_net_votes < 0) begin
            n_side = i_cfg.reverse_side ? tvdg_pkg::SIDE_LONG : tvdg_pkg::SIDE_SHORT;
            w_pick = i_snap.short_found ? tvdg_pkg::PICK_SHORT : tvdg_pkg::PICK_NONE;
        end else begin
            n_side = tvdg_pkg::SIDE_FLAT;
            // Balanced votes: larger magnitude, then lower index.
            if (i_snap.long_found && i_snap.short_found) begin
                if (i_long_abs > i_short_abs) begin
                    w_pick = tvdg_pkg::PICK_LONG;
                end else if (i_short_abs > i_long_abs) begin
                    w_pick = tvdg_pkg::PICK_SHORT;
                end else if (i_snap.long_idx < i_snap.short_idx) begin
                    w_pick = tvdg_pkg::PICK_LONG;
                end else begin
                    w_pick = tvdg_pkg::PICK_SHORT;
                end
            end else if (i_snap.long_found) begin
                w_pick = tvdg_pkg::PICK_LONG;
            end else if (i_snap.short_found) begin
                w_pick = tvdg_pkg::PICK_SHORT;
            end else begin
                w_pick = tvdg_pkg::PICK_NONE;
            end
        end

        // Winner fields read as zero when there is no voter.
        case (w_pick)
            tvdg_pkg::PICK_LONG: begin
                n_win_idx    = i_snap.long_idx;
                n_win_pred   = i_long_pred;
                n_win_width  = i_cfg.width_long;
                n_win_center = i_cfg.center_long;
            end
            tvdg_pkg::PICK_SHORT: begin
                n_win_idx    = i_snap.short_idx;
                n_win_pred   = i_short_pred;
                n_win_width  = i_cfg.width_short;
                n_win_center = i_cfg.center_short;
            end
            default: begin
                n_win_idx    = '0;
                n_win_pred   = '0;
                n_win_width  = '0;
                n_win_center = '0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_snap.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_long_votes  <= i_snap.long_cnt;
            r_short_votes <= i_snap.short_cnt;
            r_total_votes <= i_snap.long_cnt + i_snap.short_cnt;
            r_net_votes   <= n_net_votes;
            r_side        <= n_side;
            r_fired       <= (n_side != tvdg_pkg::SIDE_FLAT);
            r_has_winner  <= (w_pick != tvdg_pkg::PICK_NONE);
            r_win_idx     <= n_win_idx;
            r_win_pred    <= n_win_pred;
            r_win_width   <= n_win_width;
            r_win_center  <= n_win_center;
        end
    end

    assign o_out.valid             = r_vld;
    assign o_out.long_votes        = r_long_votes;
    assign o_out.short_votes       = r_short_votes;
    assign o_out.total_votes       = r_total_votes;
    assign o_out.net_votes         = r_net_votes;
    assign o_out.side              = r_side;
    assign o_out.fired             = r_fired;
    assign o_out.has_winner        = r_has_winner;
    assign o_out.winner_index      = r_win_idx;
    assign o_out.winner_prediction = r_win_pred;
    assign o_out.winner_width      = r_win_width;
    assign o_out.winner_center     = r_win_center;

endmodule

// ----- hw/rtl/threshold_vote_decision_gate_top.sv -----
// Top level of the threshold vote decision gate.
//
// Usage:
//  i_in carries one regime prediction per transaction, with its leg, an invalid
//  flag and a last-regime mark. A long-leg item votes when its prediction is
//  above center_long + width_long, a short-leg item when it is below
//  center_short - width_short. The last item of a decision closes it.
//  o_out carries one result transaction per decision: vote counts, net count,
//  side and the representative voter. Items without the last mark give none.
//  i_cfg writes the five configuration registers by index and is always ready;
//  the user writes it only while no decision is in flight; the block does not enforce it.
//  Throughput is one item per cycle through the classify, update and result
//  stages while nothing is stalled. The last item of a decision passes the input,
//  classified item and snapshot registers into the output register of o_out.
//  When o_out is stalled the result holds in the output register and the next
//  result waits in the snapshot register. Items keep flowing into the vote
//  state until a closing item reaches it; that item waits, one more item is
//  taken into the input register, and i_in then holds ready low.
//  Reset loads the default thresholds, clears the vote counters and found flags
//  and empties the pipeline; the block is ready as soon as reset is released.
module threshold_vote_decision_gate_top #(
    parameter int PRED_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tvdg_in_if.sink     i_in,
    tvdg_cfg_if.sink    i_cfg,
    tvdg_out_if.source  o_out
);
    tvdg_pkg::t_cfg               r_cfg;
    tvdg_pkg::t_vote_ctl          w_vote_ctl;
    logic signed [PRED_WIDTH-1:0] w_vote_pred;
    logic [PRED_WIDTH-1:0]        w_vote_abs;
    logic                         w_accum_rdy;
    tvdg_pkg::t_snap_ctl          w_snap;
    logic [PRED_WIDTH-1:0]        w_long_abs, w_short_abs;
    logic signed [PRED_WIDTH-1:0] w_long_pred, w_short_pred;
    logic                         w_result_rdy;

    // Configuration registers; writes to unused indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_long   <= tvdg_pkg::WIDTH_RESET;
            r_cfg.width_short  <= tvdg_pkg::WIDTH_RESET;
            r_cfg.center_long  <= '0;
            r_cfg.center_short <= '0;
            r_cfg.reverse_side <= 1'b0;
        end else if (i_cfg.valid) begin
            case (tvdg_pkg::t_cfg_reg'(i_cfg.index))
                tvdg_pkg::REG_WIDTH_LONG: begin
                    r_cfg.width_long <= i_cfg.data[tvdg_pkg::WIDTH_W-1:0];
                end
                tvdg_pkg::REG_WIDTH_SHORT: begin
                    r_cfg.width_short <= i_cfg.data[tvdg_pkg::WIDTH_W-1:0];
                end
                tvdg_pkg::REG_CENTER_LONG: begin
                    r_cfg.center_long <= $signed(i_cfg.data[tvdg_pkg::CENTER_W-1:0]);
                end
                tvdg_pkg::REG_CENTER_SHORT: begin
                    r_cfg.center_short <= $signed(i_cfg.data[tvdg_pkg::CENTER_W-1:0]);
                end
                tvdg_pkg::REG_REVERSE_SIDE: begin
                    r_cfg.reverse_side <= i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register and threshold compare.
    tvdg_classify #(
        .PRED_WIDTH (PRED_WIDTH)
    ) u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_rdy   (w_accum_rdy),
        .o_ctl   (w_vote_ctl),
        .o_pred  (w_vote_pred),
        .o_abs   (w_vote_abs)
    );

    // Vote counting and best-voter tracking.
    tvdg_accum #(
        .PRED_WIDTH (PRED_WIDTH)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_vote_ctl),
        .i_pred       (w_vote_pred),
        .i_abs        (w_vote_abs),
        .o_rdy        (w_accum_rdy),
        .i_rdy        (w_result_rdy),
        .o_snap       (w_snap),
        .o_long_abs   (w_long_abs),
        .o_long_pred  (w_long_pred),
        .o_short_abs  (w_short_abs),
        .o_short_pred (w_short_pred)
    );

    // Decision result and output register.
    tvdg_result #(
        .PRED_WIDTH (PRED_WIDTH)
    ) u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_snap       (w_snap),
        .i_long_abs   (w_long_abs),
        .i_long_pred  (w_long_pred),
        .i_short_abs  (w_short_abs),
        .i_short_pred (w_short_pred),
        .o_rdy        (w_result_rdy),
        .o_out        (o_out)
    );

    // A closed decision never holds more votes than items it may count.
    a_snap_votes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_snap.vld |-> ({1'b0, w_snap.long_cnt} + {1'b0, w_snap.short_cnt}
                        <= (tvdg_pkg::CNT_W + 1)'(tvdg_pkg::MAX_REGIMES)))
        else $error("closed decision holds more votes than items");

    // A majority leg always has a best voter of its own.
    a_majority_has_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.net_votes != 0) |-> o_out.has_winner)
        else $error("nonzero net count without a representative voter");

    // Fired follows the side, and winner fields are zero without a voter.
    a_fired_matches_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.fired == (o_out.side != tvdg_pkg::SIDE_FLAT)))
        else $error("fired flag disagrees with side");

    a_no_winner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.has_winner |->
            (o_out.winner_index == '0) && (o_out.winner_prediction == '0)
            && (o_out.winner_width == '0) && (o_out.winner_center == '0))
        else $error("winner fields not cleared without a voter");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the threshold vote decision gate with a vote-counting predictor.
module testbench;

    localparam int PRED_W        = 32;
    localparam int TOTAL_ITEMS   = 1850;
    localparam int PHASE_ITEMS   = 230;
    localparam int SETTLE_CYCLES = 8;

    localparam int WIDTH_W    = tvdg_pkg::WIDTH_W;
    localparam int CENTER_W   = tvdg_pkg::CENTER_W;
    localparam int CNT_W      = tvdg_pkg::CNT_W;
    localparam int NET_W      = tvdg_pkg::NET_W;
    localparam int SIDE_W     = tvdg_pkg::SIDE_W;
    localparam int IDX_W      = tvdg_pkg::IDX_W;
    localparam int CFG_DATA_W = tvdg_pkg::CFG_DATA_W;

    localparam longint PRED_MAX = 64'sd2147483647;
    localparam longint PRED_MIN = -64'sd2147483648;

    localparam logic [WIDTH_W-1:0]         WIDTH_MAX  = '1;
    localparam logic signed [CENTER_W-1:0] CENTER_MAX = 32'sh7fff_ffff;
    localparam logic signed [CENTER_W-1:0] CENTER_MIN = 32'sh8000_0000;

    // Leg encodings of an input transaction.
    localparam logic LEG_LONG  = 1'b0;
    localparam logic LEG_SHORT = 1'b1;

    typedef struct {
        logic                     leg;
        logic signed [PRED_W-1:0] prediction;
        logic                     invalid;
        logic                     last;
    } t_regime;

    typedef struct {
        logic [CNT_W-1:0]           long_votes;
        logic [CNT_W-1:0]           short_votes;
        logic [CNT_W-1:0]           total_votes;
        logic signed [NET_W-1:0]    net_votes;
        logic signed [SIDE_W-1:0]   side;
        logic                       fired;
        logic                       has_winner;
        logic [IDX_W-1:0]           winner_index;
        logic signed [PRED_W-1:0]   winner_prediction;
        logic [WIDTH_W-1:0]         winner_width;
        logic signed [CENTER_W-1:0] winner_center;
    } t_decision;

    // Tracks thresholds and vote state, and holds the decisions still owed by the block.
    class decision_predictor;
        logic [WIDTH_W-1:0]         width_long;
        logic [WIDTH_W-1:0]         width_short;
        logic signed [CENTER_W-1:0] center_long;
        logic signed [CENTER_W-1:0] center_short;
        logic                       reverse_side;
        int                         item_count;
        int                         long_count;
        int                         short_count;
        bit                         long_found;
        bit                         short_found;
        longint                     long_abs;
        longint                     short_abs;
        longint                     long_pred;
        longint                     short_pred;
        int                         long_idx;
        int                         short_idx;
        t_decision                  pending[$];
        int                         errors;

        function new();
            width_long   = tvdg_pkg::WIDTH_RESET;
            width_short  = tvdg_pkg::WIDTH_RESET;
            center_long  = '0;
            center_short = '0;
            reverse_side = 1'b0;
            errors       = 0;
            clear_votes();
        endfunction

        function void clear_votes();
            item_count  = 0;
            long_count  = 0;
            short_count = 0;
            long_found  = 0;
            short_found = 0;
            long_abs    = 0;
            short_abs   = 0;
            long_pred   = 0;
            short_pred  = 0;
            long_idx    = 0;
            short_idx   = 0;
        endfunction

        function void write_reg(tvdg_pkg::t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                tvdg_pkg::REG_WIDTH_LONG:   width_long   = value[WIDTH_W-1:0];
                tvdg_pkg::REG_WIDTH_SHORT:  width_short  = value[WIDTH_W-1:0];
                tvdg_pkg::REG_CENTER_LONG:  center_long  = value;
                tvdg_pkg::REG_CENTER_SHORT: center_short = value;
                tvdg_pkg::REG_REVERSE_SIDE: reverse_side = value[0];
                default: ;
            endcase
        endfunction

        // Classify one accepted regime and close the decision on its last mark.
        function void accept_regime(t_regime it);
            longint p;
            longint mag;
            int     idx;
            if (item_count < tvdg_pkg::MAX_REGIMES) begin
                idx = item_count;
                item_count++;
                p   = it.prediction;
                mag = (p < 0) ? -p : p;
                if (!it.invalid) begin
                    if (it.leg == LEG_LONG) begin
                        if (p > longint'(center_long) + longint'(width_long)) begin
                            long_count++;
                            if (!long_found || mag > long_abs) begin
                                long_found = 1;
                                long_abs   = mag;
                                long_idx   = idx;
                                long_pred  = p;
                            end
                        end
                    end else begin
                        if (p < longint'(center_short) - longint'(width_short)) begin
                            short_count++;
                            if (!short_found || mag > short_abs) begin
                                short_found = 1;
                                short_abs   = mag;
                                short_idx   = idx;
                                short_pred  = p;
                            end
                        end
                    end
                end
            end
            if (it.last) begin
                pending.push_back(close_decision());
            end
        endfunction

        function t_decision close_decision();
            t_decision       r;
            int              net;
            tvdg_pkg::t_pick pick;
            net  = long_count - short_count;
            pick = tvdg_pkg::PICK_NONE;
            // The majority leg supplies the voter; a tie goes to the larger magnitude, then the lower index.
            if (net > 0) begin
                pick = long_found ? tvdg_pkg::PICK_LONG : tvdg_pkg::PICK_NONE;
            end else if (net < 0) begin
                pick = short_found ? tvdg_pkg::PICK_SHORT : tvdg_pkg::PICK_NONE;
            end else if (long_found && short_found) begin
                if (long_abs > short_abs) pick = tvdg_pkg::PICK_LONG;
                else if (short_abs > long_abs) pick = tvdg_pkg::PICK_SHORT;
                else pick = (long_idx < short_idx) ? tvdg_pkg::PICK_LONG : tvdg_pkg::PICK_SHORT;
            end else if (long_found) begin
                pick = tvdg_pkg::PICK_LONG;
            end else if (short_found) begin
                pick = tvdg_pkg::PICK_SHORT;
            end

            r.long_votes  = CNT_W'(long_count);
            r.short_votes = CNT_W'(short_count);
            r.total_votes = CNT_W'(long_count + short_count);
            r.net_votes   = NET_W'(net);
            if (net > 0) r.side = reverse_side ? tvdg_pkg::SIDE_SHORT : tvdg_pkg::SIDE_LONG;
            else if (net < 0) r.side = reverse_side ? tvdg_pkg::SIDE_LONG : tvdg_pkg::SIDE_SHORT;
            else r.side = tvdg_pkg::SIDE_FLAT;
            r.fired      = (net != 0);
            r.has_winner = (pick != tvdg_pkg::PICK_NONE);
            case (pick)
                tvdg_pkg::PICK_LONG: begin
                    r.winner_index      = IDX_W'(long_idx);
                    r.winner_prediction = PRED_W'(long_pred);
                    r.winner_width      = width_long;
                    r.winner_center     = center_long;
                end
                tvdg_pkg::PICK_SHORT: begin
                    r.winner_index      = IDX_W'(short_idx);
                    r.winner_prediction = PRED_W'(short_pred);
                    r.winner_width      = width_short;
                    r.winner_center     = center_short;
                end
                default: begin
                    r.winner_index      = '0;
                    r.winner_prediction = '0;
                    r.winner_width      = '0;
                    r.winner_center     = '0;
                end
            endcase
            clear_votes();
            return r;
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_decision(t_decision got);
            t_decision want;
            if (pending.size() == 0) begin
                $error("decision transaction arrived with no decision pending");
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("long_votes", want.long_votes, got.long_votes);
            compare_field("short_votes", want.short_votes, got.short_votes);
            compare_field("total_votes", want.total_votes, got.total_votes);
            compare_field("net_votes", want.net_votes, got.net_votes);
            compare_field("side", want.side, got.side);
            compare_field("fired", want.fired, got.fired);
            compare_field("has_winner", want.has_winner, got.has_winner);
            compare_field("winner_index", want.winner_index, got.winner_index);
            compare_field("winner_prediction", want.winner_prediction, got.winner_prediction);
            compare_field("winner_width", want.winner_width, got.winner_width);
            compare_field("winner_center", want.winner_center, got.winner_center);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tvdg_in_if  #(.PRED_WIDTH(PRED_W)) in_if ();
    tvdg_cfg_if                        cfg_if ();
    tvdg_out_if #(.PRED_WIDTH(PRED_W)) out_if ();

    threshold_vote_decision_gate_top #(.PRED_WIDTH(PRED_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    decision_predictor book = new();

    int     burst_left = 0;
    int     items_sent = 0;
    int     rx_mode    = 0;
    int     rx_left    = 0;
    int     rx_phase   = 0;
    longint tie_mag [3];

    // Free-running clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run-time limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // The receiver stalls on its own pattern, switching at random among four modes.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(40, 200);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(0, 1));
            2:       out_if.ready <= ((rx_phase % 7) < 4);
            default: out_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Observe every transaction on the three channels at the rising edge.
    always @(posedge i_clk) begin
        t_regime   seen;
        t_decision got;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                book.write_reg(tvdg_pkg::t_cfg_reg'(cfg_if.index), cfg_if.data);
            end
            if (in_if.valid && in_if.ready) begin
                seen.leg        = in_if.leg;
                seen.prediction = in_if.prediction;
                seen.invalid    = in_if.pred_invalid;
                seen.last       = in_if.last_regime;
                book.accept_regime(seen);
            end
            if (out_if.valid && out_if.ready) begin
                got.long_votes        = out_if.long_votes;
                got.short_votes       = out_if.short_votes;
                got.total_votes       = out_if.total_votes;
                got.net_votes         = out_if.net_votes;
                got.side              = out_if.side;
                got.fired             = out_if.fired;
                got.has_winner        = out_if.has_winner;
                got.winner_index      = out_if.winner_index;
                got.winner_prediction = out_if.winner_prediction;
                got.winner_width      = out_if.winner_width;
                got.winner_center     = out_if.winner_center;
                book.check_decision(got);
            end
        end
    end

    // Send one regime; the sender runs in bursts with random gaps between them.
    task automatic send_item(t_regime it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_if.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        in_if.valid        <= 1'b1;
        in_if.leg          <= it.leg;
        in_if.prediction   <= it.prediction;
        in_if.pred_invalid <= it.invalid;
        in_if.last_regime  <= it.last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        burst_left--;
        items_sent++;
    endtask

    task automatic write_reg(tvdg_pkg::t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Stop sending, wait for every owed decision, then let the pipeline empty.
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_thresholds(logic [WIDTH_W-1:0] wl, logic [WIDTH_W-1:0] ws,
                                      logic signed [CENTER_W-1:0] cl,
                                      logic signed [CENTER_W-1:0] cs, logic rev);
        write_reg(tvdg_pkg::REG_WIDTH_LONG, CFG_DATA_W'(wl));
        write_reg(tvdg_pkg::REG_WIDTH_SHORT, CFG_DATA_W'(ws));
        write_reg(tvdg_pkg::REG_CENTER_LONG, cl);
        write_reg(tvdg_pkg::REG_CENTER_SHORT, cs);
        write_reg(tvdg_pkg::REG_REVERSE_SIDE, CFG_DATA_W'(rev));
    endtask

    function automatic logic [WIDTH_W-1:0] random_width();
        case ($urandom_range(0, 3))
            0:       return tvdg_pkg::WIDTH_RESET;
            1:       return WIDTH_MAX;
            2:       return WIDTH_W'($urandom_range(3355, 1 << 24));
            default: return WIDTH_W'($urandom_range(3355, 32'h7fff_ffff));
        endcase
    endfunction

    function automatic logic signed [CENTER_W-1:0] random_center();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return CENTER_MIN;
            2:       return CENTER_MAX;
            3:       return $urandom_range(0, 1 << 27) - (1 << 26);
            default: return $urandom;
        endcase
    endfunction

    // The first phases pin the threshold extremes; later ones draw settings at random.
    task automatic pick_thresholds(int phase);
        case (phase)
            0:       program_thresholds(WIDTH_MAX, WIDTH_MAX, CENTER_MIN, CENTER_MAX, 1'b1);
            1:       program_thresholds(tvdg_pkg::WIDTH_RESET, tvdg_pkg::WIDTH_RESET,
                                        CENTER_MAX, CENTER_MIN, 1'b0);
            2:       program_thresholds('0, WIDTH_W'(1), '0, '0, 1'b1);
            default: program_thresholds(random_width(), random_width(), random_center(),
                                        random_center(), 1'($urandom_range(0, 1)));
        endcase
    endtask

    function automatic longint clamp_pred(longint v);
        if (v > PRED_MAX) return PRED_MAX;
        if (v < PRED_MIN) return PRED_MIN;
        return v;
    endfunction

    function automatic longint leg_threshold(logic leg);
        if (leg == LEG_LONG) return longint'(book.center_long) + longint'(book.width_long);
        return longint'(book.center_short) - longint'(book.width_short);
    endfunction

    // A prediction that votes on its leg, mostly close to the threshold or spread widely.
    function automatic longint vote_value(logic leg);
        longint          thr;
        longint          span;
        longint          off;
        longint unsigned r;
        thr = leg_threshold(leg);
        if (leg == LEG_LONG) begin
            if (thr >= PRED_MAX) return PRED_MAX;
            span = PRED_MAX - thr;
        end else begin
            if (thr <= PRED_MIN) return PRED_MIN;
            span = thr - PRED_MIN;
        end
        r   = {$urandom, $urandom};
        off = $urandom_range(0, 1) ? longint'(r % span)
                                   : longint'($urandom_range(0, 15)) % span;
        return (leg == LEG_LONG) ? thr + 1 + off : thr - 1 - off;
    endfunction

    function automatic longint regime_pred(logic leg, int vote_pct);
        longint thr;
        int     v;
        thr = leg_threshold(leg);
        v   = $urandom;
        if ($urandom_range(0, 99) < vote_pct) return vote_value(leg);
        case ($urandom_range(0, 4))
            0: return clamp_pred(thr + longint'($urandom_range(0, 4)) - 2);
            1: return v;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return PRED_MAX;
                    1:       return PRED_MIN;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            3: begin
                v = $urandom_range(0, 2);
                return (leg == LEG_LONG) ? tie_mag[v] : -tie_mag[v];
            end
            default: return longint'($urandom_range(0, 1 << 17)) - (1 << 16);
        endcase
    endfunction

    // One decision of random regimes; equal magnitudes on both legs provoke ties.
    task automatic run_decision(int len, int vote_pct, int short_pct, int inv_pct);
        t_regime it;
        longint  lo;
        lo = leg_threshold(LEG_LONG);
        if (-leg_threshold(LEG_SHORT) > lo) lo = -leg_threshold(LEG_SHORT);
        lo = lo + 1;
        if (lo < 0) lo = 0;
        for (int k = 0; k < 3; k++) begin
            if (lo > PRED_MAX) tie_mag[k] = $urandom_range(0, 32'h7fff_ffff);
            else tie_mag[k] = lo + longint'({$urandom, $urandom} % (PRED_MAX - lo + 1));
        end
        for (int i = 0; i < len; i++) begin
            it.leg        = ($urandom_range(0, 99) < short_pct) ? LEG_SHORT : LEG_LONG;
            it.prediction = PRED_W'(regime_pred(it.leg, vote_pct));
            it.invalid    = ($urandom_range(0, 99) < inv_pct);
            it.last       = (i == len - 1);
            send_item(it);
        end
    endtask

    task automatic random_decision();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, 16);
        else if (r < 95) len = $urandom_range(17, 63);
        else len = $urandom_range(64, 80);
        run_decision(len, $urandom_range(0, 100), $urandom_range(0, 100),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 8));
    endtask

    function automatic t_regime regime(logic leg, longint pred, logic inv, logic last);
        t_regime it;
        it.leg        = leg;
        it.prediction = PRED_W'(pred);
        it.invalid    = inv;
        it.last       = last;
        return it;
    endfunction

    initial begin
        int phase;
        int phase_start;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.leg          = LEG_LONG;
        in_if.prediction   = '0;
        in_if.pred_invalid = 1'b0;
        in_if.last_regime  = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = tvdg_pkg::REG_WIDTH_LONG;
        cfg_if.data        = '0;
        out_if.ready       = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed decisions under the reset thresholds: edges, extremes, invalid and ties.
        send_item(regime(LEG_LONG, 3356, 0, 0));
        send_item(regime(LEG_LONG, 3355, 0, 0));
        send_item(regime(LEG_SHORT, -3356, 0, 0));
        send_item(regime(LEG_SHORT, -3355, 0, 0));
        send_item(regime(LEG_LONG, PRED_MAX, 0, 0));
        send_item(regime(LEG_SHORT, PRED_MIN, 0, 0));
        send_item(regime(LEG_LONG, PRED_MAX, 1, 0));
        send_item(regime(LEG_SHORT, PRED_MIN, 0, 0));
        send_item(regime(LEG_SHORT, 0, 0, 1));
        send_item(regime(LEG_LONG, PRED_MAX, 0, 0));
        send_item(regime(LEG_SHORT, PRED_MIN, 0, 1));
        send_item(regime(LEG_LONG, 5000, 0, 0));
        send_item(regime(LEG_SHORT, -5000, 0, 1));
        send_item(regime(LEG_SHORT, -5000, 0, 0));
        send_item(regime(LEG_LONG, 5000, 0, 1));
        send_item(regime(LEG_LONG, 0, 0, 1));
        send_item(regime(LEG_LONG, 9999, 1, 1));
        send_item(regime(LEG_SHORT, -9999, 0, 0));
        send_item(regime(LEG_LONG, 4000, 0, 1));
        settle();

        // Random phases, each under its own thresholds, written only while idle.
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            pick_thresholds(phase);
            phase_start = items_sent;
            if (phase == 0) begin
                // Decisions at and beyond the regime limit; the first two fill one leg to it.
                run_decision(70, 100, 0, 0);
                run_decision(66, 100, 100, 0);
                run_decision(64, 60, 50, 5);
            end
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < TOTAL_ITEMS) begin
                random_decision();
                if ($urandom_range(0, 9) == 0) settle();
            end
            settle();
            phase++;
        end

        if (book.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/tvdg_pkg.sv
hw/rtl/tvdg_in_if.sv
hw/rtl/tvdg_cfg_if.sv
hw/rtl/tvdg_out_if.sv
hw/rtl/tvdg_classify.sv
hw/rtl/tvdg_accum.sv
hw/rtl/tvdg_result.sv
hw/rtl/threshold_vote_decision_gate_top.sv
test/testbench.sv
